[rtl/core/segi_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segi_pkg - shared types and widths for the segment intersection pipeline
// Coordinate format, internal word widths derived from it, channel items and
// the operand bundle of the rounding divider.
// ----------------------------------------------------------------------------
package segi_pkg;

	// coordinate word (signed fixed point, fraction position does not matter)
	localparam int CW    = 32;
	// segment differences carry one more bit
	localparam int DW    = CW + 1;
	// signed product of two differences
	localparam int PW    = 2 * DW;
	// signed cross product: difference of two products
	localparam int XW    = PW + 1;
	// magnitude of a normalised cross product
	localparam int MAGW  = 2 * CW + 2;
	// split of the t numerator for the partial products
	localparam int LOW   = MAGW / 2;
	localparam int HIW   = MAGW - LOW;
	// t numerator times direction magnitude
	localparam int PRODW = MAGW + CW;
	// rounding numerator 2*tn*|s| + d
	localparam int NW    = PRODW + 1;
	// rounding denominator 2*d
	localparam int DENW  = MAGW + 1;
	// quotient (offset magnitude along one axis)
	localparam int QW    = CW;
	// start plus signed offset before the clamp
	localparam int SUMW  = CW + 2;

	localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};

	typedef struct packed {
		logic signed [CW-1:0] p_start_x;
		logic signed [CW-1:0] p_start_y;
		logic signed [CW-1:0] p_end_x;
		logic signed [CW-1:0] p_end_y;
		logic signed [CW-1:0] q_start_x;
		logic signed [CW-1:0] q_start_y;
		logic signed [CW-1:0] q_end_x;
		logic signed [CW-1:0] q_end_y;
	} seg_pair_t;

	typedef struct packed {
		logic                 hit;
		logic signed [CW-1:0] cross_x;
		logic signed [CW-1:0] cross_y;
	} seg_cross_t;

	typedef struct packed {
		logic [NW-1:0]   num;
		logic [DENW-1:0] den;
	} div_in_t;

endpackage

[rtl/core/segi_ifs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segi_ifs - valid/ready channels of the segment intersection block
// One interface for the segment pair items, one for the result items.
// ----------------------------------------------------------------------------
interface segi_req_if;
	logic                 valid;
	logic                 ready;
	segi_pkg::seg_pair_t  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface segi_rsp_if;
	logic                 valid;
	logic                 ready;
	segi_pkg::seg_cross_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/segi_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segi_div - pipelined restoring divider, one quotient bit per stage
// Takes num < den * 2^QW and returns floor(num / den) after QW stages.
// ----------------------------------------------------------------------------
module segi_div (
	input  logic                       clk,
	input  logic                       en,
	input  segi_pkg::div_in_t          op,
	output logic [segi_pkg::QW-1:0]    quo
);

	typedef struct packed {
		logic [segi_pkg::DENW-1:0] rem;
		logic [segi_pkg::QW-1:0]   low;
		logic [segi_pkg::QW-1:0]   q;
		logic [segi_pkg::DENW-1:0] den;
	} stage_t;

	// bring down the next numerator bit, subtract the divisor where it fits
	function automatic stage_t div_step(input stage_t cur);
		logic [segi_pkg::DENW:0]   trial;
		logic [segi_pkg::DENW+1:0] diff;
		stage_t                    nxt;
		trial    = {cur.rem, cur.low[segi_pkg::QW-1]};
		diff     = {1'b0, trial} - {2'b00, cur.den};
		nxt.den  = cur.den;
		nxt.low  = {cur.low[segi_pkg::QW-2:0], 1'b0};
		if (!diff[segi_pkg::DENW+1]) begin
			nxt.rem = diff[segi_pkg::DENW-1:0];
			nxt.q   = {cur.q[segi_pkg::QW-2:0], 1'b1};
		end else begin
			nxt.rem = trial[segi_pkg::DENW-1:0];
			nxt.q   = {cur.q[segi_pkg::QW-2:0], 1'b0};
		end
		return nxt;
	endfunction

	stage_t first;
	stage_t stg_s [segi_pkg::QW];

	always_comb begin
		first.rem = op.num[segi_pkg::NW-1:segi_pkg::QW];
		first.low = op.num[segi_pkg::QW-1:0];
		first.q   = '0;
		first.den = op.den;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			stg_s[0] <= div_step(first);
		end
	end

	for (genvar gi = 1; gi < segi_pkg::QW; gi++) begin : g_stage
		always_ff @(posedge clk) begin
			if (en) begin
				stg_s[gi] <= div_step(stg_s[gi-1]);
			end
		end
	end

	assign quo = stg_s[segi_pkg::QW-1].q;

endmodule

[rtl/core/segment_intersection_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_intersection_top - pipelined 2D line segment intersection
// Exact cross products, parameter range test and a rounded point on P.
// ----------------------------------------------------------------------------
//
//  port | role   | item        | fields
//  -----+--------+-------------+--------------------------------------------
//  req  | sink   | segment pair| p_start_x/y, p_end_x/y, q_start_x/y, q_end_x/y
//  rsp  | source | result      | hit, cross_x, cross_y
//
//  One item per cycle in and out while rsp is not stalled. From acceptance to
//  the result on rsp an item passes seven arithmetic stages, one
//  stage per quotient bit in the rounding divider, then the output register.
//  Stalls: the whole pipeline advances together; the output register plus a
//  skid entry take the item leaving the last stage, and req is held off only
//  while the skid entry is occupied. Reset clears all valid bits, not payload.
//
module segment_intersection_top (
	input  logic              clk,
	input  logic              arst_n,
	segi_req_if.sink          req,
	segi_rsp_if.source        rsp
);

	localparam int CW    = segi_pkg::CW;
	localparam int DW    = segi_pkg::DW;
	localparam int PW    = segi_pkg::PW;
	localparam int XW    = segi_pkg::XW;
	localparam int MAGW  = segi_pkg::MAGW;
	localparam int LOW   = segi_pkg::LOW;
	localparam int HIW   = segi_pkg::HIW;
	localparam int PRODW = segi_pkg::PRODW;
	localparam int NW    = segi_pkg::NW;
	localparam int QW    = segi_pkg::QW;
	localparam int SUMW  = segi_pkg::SUMW;

	// data that rides alongside the divider
	typedef struct packed {
		logic                 hit;
		logic                 neg_x;
		logic                 neg_y;
		logic signed [CW-1:0] start_x;
		logic signed [CW-1:0] start_y;
	} side_t;

	logic en;
	logic push;

	// stage 1: segment directions and offset between starts
	logic                 v_s1;
	logic signed [DW-1:0] s1x_s1, s1y_s1, s2x_s1, s2y_s1, wx_s1, wy_s1;
	logic signed [CW-1:0] px_s1, py_s1;

	// stage 2: the six products
	logic                 v_s2;
	logic signed [PW-1:0] pa_s2, pb_s2, pc_s2, pd_s2, pe_s2, pf_s2;
	logic signed [DW-1:0] s1x_s2, s1y_s2;
	logic signed [CW-1:0] px_s2, py_s2;

	// stage 3: denominator and both numerators
	logic                 v_s3;
	logic signed [XW-1:0] d_s3, sn_s3, tn_s3;
	logic signed [DW-1:0] s1x_s3, s1y_s3;
	logic signed [CW-1:0] px_s3, py_s3;

	// stage 4: sign-normalised cross products, direction magnitudes
	logic                 v_s4;
	logic signed [XW-1:0] d_s4, sn_s4, tn_s4;
	logic [CW-1:0]        ax_s4, ay_s4;
	logic                 nx_s4, ny_s4;
	logic signed [CW-1:0] px_s4, py_s4;

	// stage 5: hit decision, partial products of tn * |s|
	logic                 v_s5;
	logic                 hit_s5;
	logic [MAGW-1:0]      dm_s5;
	logic [LOW+CW-1:0]    xlo_s5, ylo_s5;
	logic [HIW+CW-1:0]    xhi_s5, yhi_s5;
	logic                 nx_s5, ny_s5;
	logic signed [CW-1:0] px_s5, py_s5;

	// stage 6: full products
	logic                 v_s6;
	logic                 hit_s6;
	logic [MAGW-1:0]      dm_s6;
	logic [PRODW-1:0]     prx_s6, pry_s6;
	logic                 nx_s6, ny_s6;
	logic signed [CW-1:0] px_s6, py_s6;

	// stage 7: rounding numerators and shared denominator
	logic                 v_s7;
	segi_pkg::div_in_t    dvx_s7, dvy_s7;
	side_t                sd_s7;

	// divider sidecar
	logic                 side_v_s [QW];
	side_t                side_s   [QW];

	logic [QW-1:0]        quo_x, quo_y;

	// output buffer
	logic                 out_v_q;
	logic                 skid_full_q;
	segi_pkg::seg_cross_t out_q, skid_q, res;

	// advance everything while the skid entry is free
	assign en        = !skid_full_q;
	assign req.ready = en;
	assign push      = en && side_v_s[QW-1];

	// ---- valid bits -------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= req.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_v_s[0] <= 1'b0;
		end else if (en) begin
			side_v_s[0] <= v_s7;
		end
	end

	for (genvar gi = 1; gi < QW; gi++) begin : g_side
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				side_v_s[gi] <= 1'b0;
			end else if (en) begin
				side_v_s[gi] <= side_v_s[gi-1];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				side_s[gi] <= side_s[gi-1];
			end
		end
	end

	// ---- arithmetic stages ------------------------------------------------
	always_ff @(posedge clk) begin
		if (en) begin
			// stage 1: differences, exact in one extra bit
			s1x_s1 <= DW'(req.data.p_end_x) - DW'(req.data.p_start_x);
			s1y_s1 <= DW'(req.data.p_end_y) - DW'(req.data.p_start_y);
			s2x_s1 <= DW'(req.data.q_end_x) - DW'(req.data.q_start_x);
			s2y_s1 <= DW'(req.data.q_end_y) - DW'(req.data.q_start_y);
			wx_s1  <= DW'(req.data.p_start_x) - DW'(req.data.q_start_x);
			wy_s1  <= DW'(req.data.p_start_y) - DW'(req.data.q_start_y);
			px_s1  <= req.data.p_start_x;
			py_s1  <= req.data.p_start_y;

			// stage 2: one signed multiply per product
			pa_s2  <= PW'(s1x_s1) * PW'(s2y_s1);
			pb_s2  <= PW'(s1y_s1) * PW'(s2x_s1);
			pc_s2  <= PW'(s1x_s1) * PW'(wy_s1);
			pd_s2  <= PW'(s1y_s1) * PW'(wx_s1);
			pe_s2  <= PW'(s2x_s1) * PW'(wy_s1);
			pf_s2  <= PW'(s2y_s1) * PW'(wx_s1);
			s1x_s2 <= s1x_s1;
			s1y_s2 <= s1y_s1;
			px_s2  <= px_s1;
			py_s2  <= py_s1;

			// stage 3: cross products
			d_s3   <= XW'(pa_s2) - XW'(pb_s2);
			sn_s3  <= XW'(pc_s2) - XW'(pd_s2);
			tn_s3  <= XW'(pe_s2) - XW'(pf_s2);
			s1x_s3 <= s1x_s2;
			s1y_s3 <= s1y_s2;
			px_s3  <= px_s2;
			py_s3  <= py_s2;

			// stage 4: flip signs so the denominator is non-negative
			if (d_s3[XW-1]) begin
				d_s4  <= -d_s3;
				sn_s4 <= -sn_s3;
				tn_s4 <= -tn_s3;
			end else begin
				d_s4  <= d_s3;
				sn_s4 <= sn_s3;
				tn_s4 <= tn_s3;
			end
			nx_s4 <= s1x_s3[DW-1];
			ny_s4 <= s1y_s3[DW-1];
			ax_s4 <= CW'(s1x_s3[DW-1] ? -s1x_s3 : s1x_s3);
			ay_s4 <= CW'(s1y_s3[DW-1] ? -s1y_s3 : s1y_s3);
			px_s4 <= px_s3;
			py_s4 <= py_s3;

			// stage 5: both parameters in [0,1], endpoints included
			hit_s5 <= (d_s4 != '0) && !sn_s4[XW-1] && !tn_s4[XW-1]
			          && (sn_s4 <= d_s4) && (tn_s4 <= d_s4);
			dm_s5  <= d_s4[MAGW-1:0];
			xlo_s5 <= (LOW+CW)'(tn_s4[LOW-1:0]) * (LOW+CW)'(ax_s4);
			xhi_s5 <= (HIW+CW)'(tn_s4[MAGW-1:LOW]) * (HIW+CW)'(ax_s4);
			ylo_s5 <= (LOW+CW)'(tn_s4[LOW-1:0]) * (LOW+CW)'(ay_s4);
			yhi_s5 <= (HIW+CW)'(tn_s4[MAGW-1:LOW]) * (HIW+CW)'(ay_s4);
			nx_s5  <= nx_s4;
			ny_s5  <= ny_s4;
			px_s5  <= px_s4;
			py_s5  <= py_s4;

			// stage 6: recombine the partial products
			prx_s6 <= {xhi_s5, {LOW{1'b0}}} + PRODW'(xlo_s5);
			pry_s6 <= {yhi_s5, {LOW{1'b0}}} + PRODW'(ylo_s5);
			hit_s6 <= hit_s5;
			dm_s6  <= dm_s5;
			nx_s6  <= nx_s5;
			ny_s6  <= ny_s5;
			px_s6  <= px_s5;
			py_s6  <= py_s5;

			// stage 7: round half away from zero on the magnitude
			dvx_s7.num    <= {prx_s6, 1'b0} + NW'(dm_s6);
			dvx_s7.den    <= {dm_s6, 1'b0};
			dvy_s7.num    <= {pry_s6, 1'b0} + NW'(dm_s6);
			dvy_s7.den    <= {dm_s6, 1'b0};
			sd_s7.hit     <= hit_s6;
			sd_s7.neg_x   <= nx_s6;
			sd_s7.neg_y   <= ny_s6;
			sd_s7.start_x <= px_s6;
			sd_s7.start_y <= py_s6;

			side_s[0] <= sd_s7;
		end
	end

	// ---- rounding dividers, one per axis ----------------------------------
	segi_div u_div_x (
		.clk (clk),
		.en  (en),
		.op  (dvx_s7),
		.quo (quo_x)
	);

	segi_div u_div_y (
		.clk (clk),
		.en  (en),
		.op  (dvy_s7),
		.quo (quo_y)
	);

	// ---- point on P, clamp, zero when missed ------------------------------
	always_comb begin
		logic signed [SUMW-1:0] off_x, off_y, sum_x, sum_y;
		logic signed [CW-1:0]   cx, cy;
		off_x = $signed(SUMW'(quo_x));
		off_y = $signed(SUMW'(quo_y));
		sum_x = SUMW'(side_s[QW-1].start_x) + (side_s[QW-1].neg_x ? -off_x : off_x);
		sum_y = SUMW'(side_s[QW-1].start_y) + (side_s[QW-1].neg_y ? -off_y : off_y);
		if (sum_x > SUMW'(segi_pkg::COORD_MAX)) begin
			cx = segi_pkg::COORD_MAX;
		end else if (sum_x < SUMW'(segi_pkg::COORD_MIN)) begin
			cx = segi_pkg::COORD_MIN;
		end else begin
			cx = sum_x[CW-1:0];
		end
		if (sum_y > SUMW'(segi_pkg::COORD_MAX)) begin
			cy = segi_pkg::COORD_MAX;
		end else if (sum_y < SUMW'(segi_pkg::COORD_MIN)) begin
			cy = segi_pkg::COORD_MIN;
		end else begin
			cy = sum_y[CW-1:0];
		end
		res.hit     = side_s[QW-1].hit;
		res.cross_x = side_s[QW-1].hit ? cx : '0;
		res.cross_y = side_s[QW-1].hit ? cy : '0;
	end

	// ---- output register and skid -----------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q     <= 1'b0;
			skid_full_q <= 1'b0;
		end else begin
			if (!out_v_q || rsp.ready) begin
				out_v_q <= skid_full_q || push;
			end
			if (out_v_q && rsp.ready) begin
				// drain the skid entry into the output register
				skid_full_q <= 1'b0;
			end else if (out_v_q && push) begin
				// output blocked: park the arriving item
				skid_full_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((!out_v_q || rsp.ready) && (skid_full_q || push)) begin
			out_q <= skid_full_q ? skid_q : res;
		end
		if (push && out_v_q && !rsp.ready) begin
			skid_q <= res;
		end
	end

	assign rsp.valid = out_v_q;
	assign rsp.data  = out_q;

	// ---- checks -------------------------------------------------------------
	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_full_q |-> out_v_q)
		else $error("skid entry occupied while output register empty");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		skid_full_q |-> !push)
		else $error("item left the pipeline while the skid entry was full");

	a_miss_is_origin: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.data.hit) |-> (rsp.data.cross_x == '0 && rsp.data.cross_y == '0))
		else $error("missed pair reported a nonzero point");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_full_q && rsp.ready) |=> !skid_full_q)
		else $error("skid entry not released after the output was taken");

endmodule

[dv/tb_segment_intersection_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_segment_intersection_top - self-checking bench for the segment crossing
// Segment pairs go in on the req channel, and each result item on rsp is
// checked against a predictor. The predictor forms the exact cross products,
// tests both parameters against [0,1] and rounds the point on P half away
// from zero. Directed cases come first, then about 1650 random pairs, with
// random gaps on the sender and random stalls on the receiver.
// ----------------------------------------------------------------------------
module tb_segment_intersection_top;
	import segi_pkg::*;

	// wide enough for 2 * tn * |s| + d with no overflow
	typedef logic signed [4*CW-1:0] big_t;

	localparam longint COORD_LO    = COORD_MIN;
	localparam longint COORD_HI    = COORD_MAX;
	// depth of the pipeline, as counted at the head of the top module
	localparam int     PIPE_DEPTH  = QW + 8;
	// cycles with no handshake on either channel before giving up
	localparam int     STALL_LIMIT = 2000;
	localparam int     MAX_WAIT    = 17;
	localparam int     RANDOM_PAIRS = 1650;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	segi_req_if req_ch ();
	segi_rsp_if rsp_ch ();

	segment_intersection_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Results predicted for accepted pairs, oldest first
	seg_cross_t crossing_q[$];

	int fail_count      = 0;
	int pairs_accepted  = 0;
	int results_checked = 0;
	int hits_seen       = 0;
	int idle_cycles     = 0;
	int send_calm       = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------

	// start + round(t_num * step / den), ties away from zero, clamped to range.
	// Callers guarantee 0 <= t_num <= den and den > 0.
	function automatic logic signed [CW-1:0] place_on_axis(input big_t start,
			input big_t t_num, input big_t step, input big_t den);
		big_t span;
		big_t off;
		big_t sum;
		span = (step < 0) ? -step : step;
		off  = (2 * t_num * span + den) / (2 * den);
		sum  = (step < 0) ? start - off : start + off;
		if (sum > big_t'(COORD_MAX))
			sum = big_t'(COORD_MAX);
		if (sum < big_t'(COORD_MIN))
			sum = big_t'(COORD_MIN);
		return sum[CW-1:0];
	endfunction

	function automatic seg_cross_t predict_crossing(input seg_pair_t pair);
		big_t p1x, p1y, p2x, p2y, q1x, q1y, q2x, q2y;
		big_t s1x, s1y, s2x, s2y, wx, wy;
		big_t den, s_num, t_num;
		seg_cross_t res;
		res = '0;
		p1x = $signed(pair.p_start_x);
		p1y = $signed(pair.p_start_y);
		p2x = $signed(pair.p_end_x);
		p2y = $signed(pair.p_end_y);
		q1x = $signed(pair.q_start_x);
		q1y = $signed(pair.q_start_y);
		q2x = $signed(pair.q_end_x);
		q2y = $signed(pair.q_end_y);
		s1x = p2x - p1x;
		s1y = p2y - p1y;
		s2x = q2x - q1x;
		s2y = q2y - q1y;
		wx  = p1x - q1x;
		wy  = p1y - q1y;
		den   = s1x * s2y - s1y * s2x;
		s_num = s1x * wy - s1y * wx;
		t_num = s2x * wy - s2y * wx;
		// parallel or degenerate: no hit, point stays at the origin
		if (den == 0)
			return res;
		// normalise so the denominator is positive
		if (den < 0) begin
			den   = -den;
			s_num = -s_num;
			t_num = -t_num;
		end
		// both parameters in [0,1], ends included
		if (s_num < 0 || t_num < 0 || s_num > den || t_num > den)
			return res;
		res.hit     = 1'b1;
		res.cross_x = place_on_axis(p1x, t_num, s1x, den);
		res.cross_y = place_on_axis(p1y, t_num, s1y, den);
		return res;
	endfunction

	// ------------------------------------------------------------------------
	// Helpers for stimulus
	// ------------------------------------------------------------------------

	// Cycles to wait before the next item: calm stretches with no idling,
	// otherwise a uniform draw over the full range.
	function automatic int draw_wait(inout int calm_left);
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm_left = $urandom_range(10, 60);
			return 0;
		end
		return $urandom_range(0, MAX_WAIT);
	endfunction

	// signed value in [-lim, lim]; lim at most 2**30
	function automatic longint rand_span(input int unsigned lim);
		return longint'($urandom_range(0, 2 * lim)) - longint'(lim);
	endfunction

	// multiplier along a direction; zero now and then to land on an end
	function automatic longint draw_reach();
		if ($urandom_range(0, 5) == 0)
			return 0;
		return $urandom_range(1, 1 << 17);
	endfunction

	function automatic longint pick_edge_coord();
		case ($urandom_range(0, 5))
			0: return COORD_LO;
			1: return COORD_HI;
			2: return 0;
			3: return -1;
			4: return 1;
			default: return longint'($urandom());
		endcase
	endfunction

	// bits above the coordinate width are dropped
	function automatic seg_pair_t make_pair(input longint ax, input longint ay,
			input longint bx, input longint by, input longint cx, input longint cy,
			input longint dx, input longint dy);
		seg_pair_t pair;
		pair.p_start_x = ax[CW-1:0];
		pair.p_start_y = ay[CW-1:0];
		pair.p_end_x   = bx[CW-1:0];
		pair.p_end_y   = by[CW-1:0];
		pair.q_start_x = cx[CW-1:0];
		pair.q_start_y = cy[CW-1:0];
		pair.q_end_x   = dx[CW-1:0];
		pair.q_end_y   = dy[CW-1:0];
		return pair;
	endfunction

	task automatic note_failure(input string what);
		fail_count++;
		if (fail_count <= 10)
			$display("ERROR at %0t ns: %s", $time, what);
	endtask

	// Offer one segment pair and hold it until accepted. Valid stays high on
	// return so that a back-to-back item needs no second assignment in the
	// same step; drop it only when a gap is drawn.
	task automatic send_pair(input seg_pair_t pair);
		int gap;
		gap = draw_wait(send_calm);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data  <= pair;
		do
			@(posedge clk);
		while (!req_ch.ready);
	endtask

	// ------------------------------------------------------------------------
	// Receiver: stall for a drawn number of cycles before every result item
	// ------------------------------------------------------------------------
	initial begin : result_sink
		int stall;
		int calm_left;
		calm_left = 0;
		rsp_ch.ready <= 1'b0;
		do
			@(posedge clk);
		while (!arst_n);
		forever begin
			stall = draw_wait(calm_left);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do
				@(posedge clk);
			while (!rsp_ch.valid);
		end
	end

	// ------------------------------------------------------------------------
	// Predict on every accepted pair, check every accepted result.
	// Sampling at the edge sees the values from before the edge on both sides.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				crossing_q.push_back(predict_crossing(req_ch.data));
				pairs_accepted++;
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (crossing_q.size() == 0) begin
					note_failure($sformatf("result with nothing outstanding: hit=%0b x=%0d y=%0d",
						rsp_ch.data.hit, rsp_ch.data.cross_x, rsp_ch.data.cross_y));
				end else begin
					seg_cross_t want;
					want = crossing_q.pop_front();
					if (rsp_ch.data.hit !== want.hit ||
						rsp_ch.data.cross_x !== want.cross_x ||
						rsp_ch.data.cross_y !== want.cross_y) begin
						note_failure($sformatf(
							"result %0d: expected hit=%0b x=%0d y=%0d, got hit=%0b x=%0d y=%0d",
							results_checked, want.hit, want.cross_x, want.cross_y,
							rsp_ch.data.hit, rsp_ch.data.cross_x, rsp_ch.data.cross_y));
					end
					if (want.hit)
						hits_seen++;
					results_checked++;
				end
			end
		end
	end

	// Watchdog: end the run if neither channel moves an item for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles == STALL_LIMIT) begin
				$display("Timeout: no handshake for %0d cycles, %0d results outstanding",
					STALL_LIMIT, crossing_q.size());
				$display("Verification failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Directed tests
	// ------------------------------------------------------------------------

	// Corners of the coordinate range, full-span diagonals and bit patterns
	task automatic test_extreme_coordinates();
		send_pair(make_pair(COORD_LO, COORD_LO, COORD_HI, COORD_HI,
			COORD_LO, COORD_HI, COORD_HI, COORD_LO));
		send_pair(make_pair(COORD_HI, COORD_LO, COORD_LO, COORD_HI,
			COORD_LO, COORD_LO, COORD_HI, COORD_HI));
		send_pair(make_pair(COORD_LO, 0, COORD_HI, 0, 0, COORD_LO, 0, COORD_HI));
		// corner touch: both parameters zero
		send_pair(make_pair(COORD_LO, COORD_LO, COORD_HI, COORD_LO,
			COORD_LO, COORD_LO, COORD_LO, COORD_HI));
		// far corner touch: both parameters one
		send_pair(make_pair(COORD_LO, COORD_HI, COORD_HI, COORD_HI,
			COORD_HI, COORD_LO, COORD_HI, COORD_HI));
		send_pair(make_pair(COORD_LO, COORD_LO, COORD_LO, COORD_LO,
			COORD_LO, COORD_LO, COORD_LO, COORD_LO));
		send_pair(make_pair(COORD_HI, COORD_HI, COORD_HI, COORD_HI,
			COORD_HI, COORD_HI, COORD_HI, COORD_HI));
		send_pair(make_pair('h5555_5555, 'hAAAA_AAAA, 'hAAAA_AAAA, 'h5555_5555,
			'h5555_5555, 'h5555_5555, 'hAAAA_AAAA, 'hAAAA_AAAA));
	endtask

	// Zero denominator: parallel, collinear and zero-length segments
	task automatic test_parallel_and_degenerate();
		send_pair(make_pair(0, 0, 10, 10, 0, 5, 10, 15));
		send_pair(make_pair(0, 0, 10, 0, 5, 0, 15, 0));
		send_pair(make_pair(3, 3, 3, 3, 0, 0, 6, 6));
		send_pair(make_pair(-4, 2, 4, 2, 0, 2, 0, 2));
	endtask

	// Lines cross, but one parameter falls outside [0,1]
	task automatic test_parameter_range();
		send_pair(make_pair(0, 0, 4, 0, 9, -1, 9, 1));
		send_pair(make_pair(0, 0, 4, 0, -5, -1, -5, 1));
		send_pair(make_pair(0, 0, 4, 0, 2, 1, 2, 3));
		send_pair(make_pair(0, 0, 4, 0, 2, -3, 2, -1));
	endtask

	// Contact exactly at an end of either segment counts as a hit
	task automatic test_endpoint_touch();
		send_pair(make_pair(0, 0, 4, 0, 4, -2, 4, 2));
		send_pair(make_pair(0, 0, 4, 0, 0, 0, 0, 5));
		send_pair(make_pair(0, 0, 4, 0, 2, -3, 2, 0));
	endtask

	// Offsets of one half round away from zero, thirds to the nearest unit
	task automatic test_rounding_ties();
		send_pair(make_pair(0, 0, 1, 0, 0, -1, 1, 1));
		send_pair(make_pair(0, 0, -1, 0, 0, -1, -1, 1));
		send_pair(make_pair(0, 0, 0, -1, -1, 0, 1, -1));
		send_pair(make_pair(0, 0, 1, 0, 0, -1, 1, 2));
		send_pair(make_pair(0, 0, 1, 0, 0, -2, 1, 1));
	endtask

	// ------------------------------------------------------------------------
	// Random pairs. Two in five are built to cross at a chosen point, so that the
	// range test passes and the rounding path is exercised; the rest are
	// parallel families, a small grid, full-range noise and edge values.
	// ------------------------------------------------------------------------
	task automatic test_random_pairs(input int count);
		seg_pair_t pair;
		int pick;
		longint cx, cy, ux, uy, vx, vy, a, b, c, e, ox, oy;
		repeat (count) begin
			pick = $urandom_range(0, 19);
			cx = rand_span(1 << 30);
			cy = rand_span(1 << 30);
			ux = rand_span(1 << $urandom_range(0, 12));
			uy = rand_span(1 << $urandom_range(0, 12));
			vx = rand_span(1 << $urandom_range(0, 12));
			vy = rand_span(1 << $urandom_range(0, 12));
			a  = draw_reach();
			b  = draw_reach();
			c  = draw_reach();
			e  = draw_reach();
			if (pick < 8) begin
				// both segments pass through (cx, cy), at an end where a reach is zero
				pair = make_pair(cx - a * ux, cy - a * uy, cx + b * ux, cy + b * uy,
					cx - c * vx, cy - c * vy, cx + e * vx, cy + e * vy);
				// snap an end of Q onto an end of P
				if (pick == 7) begin
					if ($urandom_range(0, 1)) begin
						pair.q_start_x = pair.p_end_x;
						pair.q_start_y = pair.p_end_y;
					end else begin
						pair.q_end_x = pair.p_start_x;
						pair.q_end_y = pair.p_start_y;
					end
				end
			end else if (pick < 11) begin
				// Q is P shifted: by multiples of the direction parts or by a random offset
				if ($urandom_range(0, 1)) begin
					ox = rand_span(1 << 17) * ux;
					oy = rand_span(1 << 17) * uy;
				end else begin
					ox = rand_span(1 << $urandom_range(0, 20));
					oy = rand_span(1 << $urandom_range(0, 20));
				end
				if ($urandom_range(0, 1))
					pair = make_pair(cx - a * ux, cy - a * uy, cx + b * ux, cy + b * uy,
						cx - a * ux + ox, cy - a * uy + oy, cx + b * ux + ox, cy + b * uy + oy);
				else
					pair = make_pair(cx - a * ux, cy - a * uy, cx + b * ux, cy + b * uy,
						cx + b * ux + ox, cy + b * uy + oy, cx - a * ux + ox, cy - a * uy + oy);
			end else if (pick < 14) begin
				pair = make_pair(rand_span(4), rand_span(4), rand_span(4), rand_span(4),
					rand_span(4), rand_span(4), rand_span(4), rand_span(4));
			end else if (pick < 17) begin
				pair = make_pair($urandom(), $urandom(), $urandom(), $urandom(),
					$urandom(), $urandom(), $urandom(), $urandom());
			end else begin
				pair = make_pair(pick_edge_coord(), pick_edge_coord(), pick_edge_coord(),
					pick_edge_coord(), pick_edge_coord(), pick_edge_coord(),
					pick_edge_coord(), pick_edge_coord());
			end
			send_pair(pair);
		end
	endtask

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------
	initial begin
		req_ch.valid <= 1'b0;
		req_ch.data  <= '0;
		// hold reset low, then release it at an edge
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extreme_coordinates();
		test_parallel_and_degenerate();
		test_parameter_range();
		test_endpoint_touch();
		test_rounding_ties();
		test_random_pairs(RANDOM_PAIRS);
		req_ch.valid <= 1'b0;

		// drain, then watch a while longer for stray result items
		while (crossing_q.size() != 0)
			@(posedge clk);
		repeat (2 * PIPE_DEPTH) @(posedge clk);
		fail_count += crossing_q.size();

		$display("Run covered %0d segment pairs and %0d checked results, %0d of them hits.",
			pairs_accepted, results_checked, hits_seen);
		$display("Cases: range corners, parallel and degenerate pairs, end contact, %s",
			"half-unit rounding, random gaps and stalls on both channels.");
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

[files.f]
rtl/core/segi_pkg.sv
rtl/core/segi_ifs.sv
rtl/core/segi_div.sv
rtl/core/segment_intersection_top.sv
dv/tb_segment_intersection_top.sv
